// File: rtl/fifo_contiguous_slot_allocator_unit_macros.svh
// Assertion macros shared by the slot allocator modules.
`ifndef FIFO_CONTIGUOUS_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define FIFO_CONTIGUOUS_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSA_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSA_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/csa_pkg.sv
// Shared constants, types and a helper function of the slot allocator.
package csa_pkg;

  localparam int SLOTS       = 16;
  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_RESULTS = 8;
  localparam int CMDQ_DEPTH  = 2;
  localparam int RESQ_DEPTH  = 4;

  localparam int TAG_W    = 8;
  localparam int CNT_W    = 5;
  localparam int START_W  = 4;
  localparam int STATUS_W = 2;

  localparam int POS_W   = $clog2(2 * SLOTS + 1);
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NRES_W  = $clog2(MAX_RESULTS + 1);

  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  localparam logic FUNC_RESERVE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_GRANTED    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    CMD_BAD_COUNT,
    CMD_RESERVE,
    CMD_RELEASE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [TAG_W-1:0]    tag;
    logic [CNT_W-1:0]    count;
    logic [START_W-1:0]  start;
  } cmd_t;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [START_W-1:0]  start;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  typedef logic [SLOTS-1:0] slot_map_t;

  // Bit i is set when start <= i < start + len.
  function automatic slot_map_t run_mask(input logic [POS_W-1:0] start,
                                         input logic [POS_W-1:0] len);
    slot_map_t        m;
    logic [POS_W-1:0] idx;
    for (int i = 0; i < SLOTS; i++) begin
      idx  = POS_W'(i);
      m[i] = (idx >= start) && (idx < start + len);
    end
    return m;
  endfunction

endpackage

// File: rtl/fifo_contiguous_slot_allocator_unit.sv
// Top level of the FIFO-ordered first-fit contiguous slot allocator.
// The block tracks 16 slots and a wait queue of up to 8 reserve requests that are
// served strictly in arrival order. An input word either reserves slot_count
// contiguous slots (func 0) or frees slot_count slots from start_slot on (func 1).
// A reserve with a count of zero or above the slot total is answered at once with
// status 2, and a good reserve that finds the wait queue full is answered with
// status 1. Otherwise the request waits, and after every reserve or release the
// engine grants the queue head the lowest-starting free run of its size, again and
// again while heads fit, at most 8 grants per input word; each grant carries the
// request's tag and the run's first slot with status 0. A release that frees
// nothing or runs past the last slot is ignored and causes no result. The word
// that ends the results of one input has last set; a reserve that only waits
// causes no result at all. Input words go through a two-entry command queue into
// the engine, and results leave through a four-entry result queue, so both sides
// stall on their own. The engine answers a rejection, or queues a reserve or applies a
// release, from its idle state, then grants queue heads one after another in its grant
// state and leaves it when a search finds no fit, the queue is empty or the grant limit
// is reached; the first-fit search over all slots is combinational and sets the pace of
// a burst. There is no clearing pass after reset.
module fifo_contiguous_slot_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            func,
  input  logic [csa_pkg::TAG_W-1:0]       req_tag,
  input  logic [csa_pkg::CNT_W-1:0]       slot_count,
  input  logic [csa_pkg::START_W-1:0]     start_slot,
  output logic                            empty,
  input  logic                            pop,
  output logic [csa_pkg::TAG_W-1:0]       grant_tag,
  output logic [csa_pkg::START_W-1:0]     grant_start,
  output logic [csa_pkg::STATUS_W-1:0]    status,
  output logic                            last
);
  import csa_pkg::*;

  logic    cmd_push;
  cmd_t    cmd_in;
  logic    cmd_full;
  logic    cmd_empty;
  logic    cmd_pop;
  cmd_t    cmd_out;
  result_t res;

  // The front end classifies each input word and drops releases that free nothing or run past the last slot.
  csa_front u_front (
    .push       (push),
    .full       (full),
    .func       (func),
    .req_tag    (req_tag),
    .slot_count (slot_count),
    .start_slot (start_slot),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .cmd_full   (cmd_full)
  );

  // Commands wait here while the engine works through a grant burst.
  csa_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  // The engine owns the occupancy map and the wait queue and emits result words.
  csa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_empty (empty),
    .res       (res),
    .res_pop   (pop)
  );

  assign grant_tag   = res.tag;
  assign grant_start = res.start;
  assign status      = res.status;
  assign last        = res.last;

endmodule

// File: rtl/csa_front.sv
// Front end: takes input words, checks counts and ranges, forms commands.
module csa_front (
  input  logic                         push,
  output logic                         full,
  input  logic                         func,
  input  logic [csa_pkg::TAG_W-1:0]    req_tag,
  input  logic [csa_pkg::CNT_W-1:0]    slot_count,
  input  logic [csa_pkg::START_W-1:0]  start_slot,
  output logic                         cmd_push,
  output csa_pkg::cmd_t                cmd,
  input  logic                         cmd_full
);
  import csa_pkg::*;

  logic [POS_W-1:0] end_pos;
  logic             count_ok;
  logic             release_ok;
  logic             accept;

  assign end_pos    = POS_W'(start_slot) + POS_W'(slot_count);
  assign count_ok   = (slot_count != '0) && (POS_W'(slot_count) <= POS_W'(SLOTS));
  // A release that runs past the last slot, or frees nothing, is dropped here.
  assign release_ok = (slot_count != '0) && (POS_W'(start_slot) < POS_W'(SLOTS)) &&
                      (end_pos <= POS_W'(SLOTS));

  assign accept   = push && !cmd_full;
  assign full     = cmd_full;
  assign cmd_push = accept && ((func == FUNC_RESERVE) || release_ok);

  always_comb begin
    cmd.tag   = req_tag;
    cmd.count = slot_count;
    cmd.start = start_slot;
    if (func == FUNC_RESERVE) begin
      cmd.op = count_ok ? CMD_RESERVE : CMD_BAD_COUNT;
    end else begin
      cmd.op = CMD_RELEASE;
    end
  end

endmodule

// File: rtl/csa_cmd_queue.sv
// Short command queue between the front end and the allocation engine.
`include "fifo_contiguous_slot_allocator_unit_macros.svh"
module csa_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  csa_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output csa_pkg::cmd_t dout,
  output logic          empty
);
  import csa_pkg::*;

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] head;
  logic [CMDQ_PTR_W-1:0] tail;
  logic [CMDQ_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CSA_ASSERT_IMPL(a_cq_bound, clk, rst, 1'b1, count <= CMDQ_CNT_W'(CMDQ_DEPTH), "overfilled")
  `CSA_ASSERT_IMPL(a_cq_ptrs, clk, rst, count == '0, head == tail, "split pointers")
  `CSA_ASSERT_NEXT(a_cq_grow, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1, "push lost")

endmodule

// File: rtl/csa_back.sv
// Allocation engine: wait queue, occupancy map, first-fit search, result queue.
`include "fifo_contiguous_slot_allocator_unit_macros.svh"
module csa_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  csa_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             res_empty,
  output csa_pkg::result_t res,
  input  logic             res_pop
);
  import csa_pkg::*;

  typedef enum logic {S_IDLE, S_GRANT} state_t;

  state_t               state;
  slot_map_t            map;
  logic [TAG_W-1:0]     wq_tag   [QUEUE_DEPTH];
  logic [CNT_W-1:0]     wq_count [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    q_head;
  logic [QPTR_W-1:0]    q_tail;
  logic [QFILL_W-1:0]   q_fill;
  logic [NRES_W-1:0]    n_grant;
  logic                 pend_valid;
  logic [TAG_W-1:0]     pend_tag;
  logic [START_W-1:0]   pend_start;

  result_t              rq [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] rq_head;
  logic [RESQ_PTR_W-1:0] rq_tail;
  logic [RESQ_CNT_W-1:0] rq_count;
  logic                 rq_full;
  logic                 rq_do_pop;

  logic [CNT_W-1:0]     head_len;
  logic [SLOTS-1:0]     fit_ok;
  logic                 fit_found;
  logic [START_W-1:0]   fit_start;
  slot_map_t            grant_mask;
  logic                 q_full;
  logic                 cont;
  logic                 stall;
  logic                 grant_fire;
  logic                 enqueue;
  logic                 res_push;
  result_t              res_data;

  assign q_full   = (q_fill == QFILL_W'(QUEUE_DEPTH));
  assign head_len = wq_count[q_head];

  // Every possible start is checked at once; the lowest free one wins.
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      fit_ok[s] = (POS_W'(s) + POS_W'(head_len) <= POS_W'(SLOTS)) &&
                  ((map & run_mask(POS_W'(s), POS_W'(head_len))) == '0);
    end
  end

  always_comb begin
    fit_found = 1'b0;
    fit_start = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (fit_ok[s]) begin
        fit_found = 1'b1;
        fit_start = START_W'(s);
      end
    end
  end

  assign grant_mask = run_mask(POS_W'(fit_start), POS_W'(head_len));
  assign cont       = (state == S_GRANT) && (q_fill != '0) &&
                      (n_grant < NRES_W'(MAX_RESULTS)) && fit_found;
  assign stall      = pend_valid && rq_full;
  assign grant_fire = cont && !stall;
  assign enqueue    = (state == S_IDLE) && cmd_valid && (cmd.op == CMD_RESERVE) && !q_full;

  // A grant is held in the pend registers so that its last flag can see whether another follows.
  always_comb begin
    res_push = 1'b0;
    res_data = '0;
    cmd_pop  = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            CMD_BAD_COUNT: begin
              res_data = '{tag: cmd.tag, start: '0, status: STATUS_BAD_COUNT, last: 1'b1};
              res_push = !rq_full;
              cmd_pop  = !rq_full;
            end
            CMD_RESERVE: begin
              if (q_full) begin
                res_data = '{tag: cmd.tag, start: '0, status: STATUS_QUEUE_FULL, last: 1'b1};
                res_push = !rq_full;
                cmd_pop  = !rq_full;
              end else begin
                cmd_pop = 1'b1;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      S_GRANT: begin
        res_data = '{tag: pend_tag, start: pend_start, status: STATUS_GRANTED, last: !cont};
        res_push = pend_valid && !rq_full;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (enqueue) begin
      wq_tag[q_tail]   <= cmd.tag;
      wq_count[q_tail] <= cmd.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      map        <= '0;
      q_head     <= '0;
      q_tail     <= '0;
      q_fill     <= '0;
      n_grant    <= '0;
      pend_valid <= 1'b0;
      pend_tag   <= '0;
      pend_start <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              CMD_RESERVE: begin
                if (!q_full) begin
                  q_tail  <= (q_tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail + 1'b1;
                  q_fill  <= q_fill + 1'b1;
                  n_grant <= '0;
                  state   <= S_GRANT;
                end
              end
              CMD_RELEASE: begin
                map     <= map & ~run_mask(POS_W'(cmd.start), POS_W'(cmd.count));
                n_grant <= '0;
                state   <= S_GRANT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_GRANT: begin
          if (!stall) begin
            if (cont) begin
              map        <= map | grant_mask;
              q_head     <= (q_head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_head + 1'b1;
              q_fill     <= q_fill - 1'b1;
              n_grant    <= n_grant + 1'b1;
              pend_valid <= 1'b1;
              pend_tag   <= wq_tag[q_head];
              pend_start <= fit_start;
            end else begin
              pend_valid <= 1'b0;
              state      <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result queue toward the output ports.
  assign rq_full   = (rq_count == RESQ_CNT_W'(RESQ_DEPTH));
  assign res_empty = (rq_count == '0);
  assign rq_do_pop = res_pop && !res_empty;
  assign res       = rq[rq_head];

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rq_tail] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_head  <= '0;
      rq_tail  <= '0;
      rq_count <= '0;
    end else begin
      if (res_push) begin
        rq_tail <= (rq_tail == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : rq_tail + 1'b1;
      end
      if (rq_do_pop) begin
        rq_head <= (rq_head == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : rq_head + 1'b1;
      end
      if (res_push && !rq_do_pop) begin
        rq_count <= rq_count + 1'b1;
      end else if (rq_do_pop && !res_push) begin
        rq_count <= rq_count - 1'b1;
      end
    end
  end

  `CSA_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, q_fill <= QFILL_W'(QUEUE_DEPTH), "overfilled")
  `CSA_ASSERT_IMPL(a_burst_bound, clk, rst, 1'b1, n_grant <= NRES_W'(MAX_RESULTS), "long burst")
  `CSA_ASSERT_IMPL(a_grant_free, clk, rst, grant_fire, (map & grant_mask) == '0, "busy grant")
  `CSA_ASSERT_NEXT(a_grant_marks, clk, rst, grant_fire, &(map | ~$past(grant_mask)), "not marked")
  `CSA_ASSERT_IMPL(a_rq_bound, clk, rst, 1'b1, rq_count <= RESQ_CNT_W'(RESQ_DEPTH), "overfilled")

endmodule
